@@ design/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types, constants and stage counts for the sensor compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    typedef logic signed [31:0] t_s32;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_TCAL   = 3'd0,
        CFG_PCAL_L = 3'd1,
        CFG_PCAL_H = 3'd2,
        CFG_PCAL_9 = 3'd3,
        CFG_HSCALE = 3'd4,
        CFG_HOFF   = 3'd5
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [23:0] RAW_SKIP24 = 24'h800000;
    localparam logic [15:0] RAW_SKIP16 = 16'h8000;
    localparam logic [13:0] HUM_MAX    = 14'd10000;

    // stage counts
    localparam int LAT_T     = 5;
    localparam int LAT_H     = 7;
    localparam int DIV_W     = 32;
    localparam int LAT_PPRE  = 5;
    localparam int LAT_PPOST = 4;
    localparam int LAT_P     = LAT_PPRE + DIV_W + LAT_PPOST;
    localparam int LAT_TOTAL = LAT_T + LAT_P;

endpackage

`default_nettype wire

@@ design/env_sensor_compensation_core.sv @@
// ----------------------------------------------------------------------------
// env_sensor_compensation_core
// Integer compensation of raw temperature, humidity and pressure readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one set of raw readings
//   per transfer; output channel (o_out_valid / i_out_stall) carries one
//   compensated result set per input transfer, in order.
//   Calibration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the core is idle; the user must keep to this, since the core itself does
//   not enforce it. Indexes outside the register list are dropped. Sets pass
//   fine temperature, pressure setup, the bit-per-stage divider and finish.
//   Throughput is one transfer per cycle; the whole pipeline advances in
//   lockstep, so a new set enters every cycle the output is not held.
//   When the receiver stalls a valid result, hold the whole pipeline and
//   raise o_in_stall; nothing is dropped or repeated.
//   Synchronous active-low reset clears the output valid chain and the calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module env_sensor_compensation_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [23:0]                     i_raw_pressure,
    input  wire logic [23:0]                     i_raw_temperature,
    input  wire logic [15:0]                     i_raw_humidity,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic signed [15:0]                   o_temperature_centi,
    output logic                                 o_temperature_valid,
    output logic [13:0]                          o_humidity_centi,
    output logic                                 o_humidity_valid,
    output logic [15:0]                          o_pressure_deca_pa,
    output logic                                 o_pressure_valid,
    output logic                                 o_status_code,
    input  wire logic                            i_cfg_we,
    input  wire logic [esc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [esc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import esc_pkg::*;

    // calibration registers
    logic [47:0] r_tcal;
    logic [63:0] r_pcal_l, r_pcal_h;
    logic [15:0] r_pcal_9;
    logic [39:0] r_hscale;
    logic [31:0] r_hoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal   <= '0;
            r_pcal_l <= '0;
            r_pcal_h <= '0;
            r_pcal_9 <= '0;
            r_hscale <= '0;
            r_hoff   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TCAL:   r_tcal   <= i_cfg_data[47:0];
                CFG_PCAL_L: r_pcal_l <= i_cfg_data;
                CFG_PCAL_H: r_pcal_h <= i_cfg_data;
                CFG_PCAL_9: r_pcal_9 <= i_cfg_data[15:0];
                CFG_HSCALE: r_hscale <= i_cfg_data[39:0];
                CFG_HOFF:   r_hoff   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // advance whenever the output slot is empty or being taken
    logic w_en;
    logic [LAT_TOTAL-1:0] r_vld;

    assign w_en       = !r_vld[LAT_TOTAL-1] || !i_out_stall;
    assign o_in_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT_TOTAL-2:0], i_in_valid};
        end
    end

    // temperature first; its fine value feeds humidity and pressure
    t_s32        w_tf;
    logic [15:0] w_temp;
    logic        w_temp_v;

    esc_temp u_temp (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_raw_t  (i_raw_temperature),
        .i_t1     (r_tcal[15:0]),
        .i_t2     (r_tcal[31:16]),
        .i_t3     (r_tcal[47:32]),
        .o_tf     (w_tf),
        .o_temp   (w_temp),
        .o_temp_v (w_temp_v)
    );

    // hold raw humidity and pressure until the fine temperature is ready
    logic [23:0] w_raw_p;
    logic [15:0] w_raw_h;

    esc_dly #(.W(40), .N(LAT_T)) u_raw_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({i_raw_pressure, i_raw_humidity}),
        .o_q   ({w_raw_p, w_raw_h})
    );

    logic [13:0] w_hum;
    logic        w_hum_v;

    esc_hum u_hum (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_tf    (w_tf),
        .i_raw_h (w_raw_h),
        .i_h1    (r_hscale[7:0]),
        .i_h2    (r_hscale[23:8]),
        .i_h3    (r_hscale[31:24]),
        .i_h4    (r_hoff[11:0]),
        .i_h5    (r_hoff[27:16]),
        .i_h6    (r_hscale[39:32]),
        .o_hum   (w_hum),
        .o_hum_v (w_hum_v)
    );

    esc_pres u_pres (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_tf     (w_tf),
        .i_raw_p  (w_raw_p),
        .i_p1     (r_pcal_l[15:0]),
        .i_p2     (r_pcal_l[31:16]),
        .i_p3     (r_pcal_l[47:32]),
        .i_p4     (r_pcal_l[63:48]),
        .i_p5     (r_pcal_h[15:0]),
        .i_p6     (r_pcal_h[31:16]),
        .i_p7     (r_pcal_h[47:32]),
        .i_p8     (r_pcal_h[63:48]),
        .i_p9     (r_pcal_9),
        .o_pres   (o_pressure_deca_pa),
        .o_pres_v (o_pressure_valid),
        .o_status (o_status_code)
    );

    // align the shorter paths with the pressure result
    esc_dly #(.W(15), .N(LAT_P - LAT_H)) u_hum_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_hum, w_hum_v}),
        .o_q   ({o_humidity_centi, o_humidity_valid})
    );

    esc_dly #(.W(17), .N(LAT_P)) u_temp_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_temp, w_temp_v}),
        .o_q   ({o_temperature_centi, o_temperature_valid})
    );

    assign o_out_valid = r_vld[LAT_TOTAL-1];

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input held without a stalled result");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status_code) |-> (o_pressure_valid && o_pressure_deca_pa == '0))
        else $error("zero divisor result not cleared");

    a_hum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_humidity_centi <= HUM_MAX))
        else $error("humidity beyond clamp");

    a_temp_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_temperature_valid) |-> (o_temperature_centi == '0))
        else $error("skipped temperature not zero");

endmodule

`default_nettype wire

@@ design/esc_dly.sv @@
// ----------------------------------------------------------------------------
// esc_dly
// Enable-gated shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_dly #(
    parameter int W = 8,
    parameter int N = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_q
);
    logic [W-1:0] r_sr [0:N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
        end
    end

    for (genvar k = 1; k < N; k++) begin : g_tap
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_q = r_sr[N-1];

endmodule

`default_nettype wire

@@ design/esc_temp.sv @@
// ----------------------------------------------------------------------------
// esc_temp
// Five-stage temperature compensation; yields fine temperature and centi-degC.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_temp (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [23:0]        i_raw_t,
    input  wire logic [15:0]        i_t1,
    input  wire logic signed [15:0] i_t2,
    input  wire logic signed [15:0] i_t3,
    output esc_pkg::t_s32           o_tf,
    output logic [15:0]             o_temp,
    output logic                    o_temp_v
);
    import esc_pkg::*;

    t_s32 w_x, w_t1, w_t2, w_t3, w_tf, w_t5;
    t_s32 r1_a, r1_d, r2_m, r2_dd, r3_v1, r3_e, r4_tf, r5_tf;
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [15:0] r5_temp;

    assign w_x  = t_s32'({12'b0, i_raw_t[23:4]});
    assign w_t1 = t_s32'({16'b0, i_t1});
    assign w_t2 = i_t2;
    assign w_t3 = i_t3;
    assign w_tf = r3_v1 + (r3_e >>> 14);
    assign w_t5 = ((r4_tf <<< 2) + r4_tf + 32'sd128) >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a    <= (w_x >>> 3) - (w_t1 <<< 1);
            r1_d    <= (w_x >>> 4) - w_t1;
            r1_v    <= (i_raw_t != RAW_SKIP24);
            r2_m    <= r1_a * w_t2;
            r2_dd   <= r1_d * r1_d;
            r2_v    <= r1_v;
            r3_v1   <= r2_m >>> 11;
            r3_e    <= (r2_dd >>> 12) * w_t3;
            r3_v    <= r2_v;
            r4_tf   <= r3_v ? w_tf : '0;
            r4_v    <= r3_v;
            r5_tf   <= r4_tf;
            r5_temp <= r4_v ? w_t5[15:0] : '0;
            r5_v    <= r4_v;
        end
    end

    assign o_tf     = r5_tf;
    assign o_temp   = r5_temp;
    assign o_temp_v = r5_v;

endmodule

`default_nettype wire

@@ design/esc_hum.sv @@
// ----------------------------------------------------------------------------
// esc_hum
// Seven-stage humidity compensation with clamp and scale to 0.01 %RH.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_hum (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  esc_pkg::t_s32           i_tf,
    input  wire logic [15:0]        i_raw_h,
    input  wire logic [7:0]         i_h1,
    input  wire logic signed [15:0] i_h2,
    input  wire logic [7:0]         i_h3,
    input  wire logic signed [11:0] i_h4,
    input  wire logic signed [11:0] i_h5,
    input  wire logic signed [7:0]  i_h6,
    output logic [13:0]             o_hum,
    output logic                    o_hum_v
);
    import esc_pkg::*;

    t_s32 w_vh, w_h5, w_h6, w_h3, w_h2, w_h1, w_r, w_c;
    logic [23:0] w_hm;
    t_s32 r1_base, r1_p5, r1_p6, r1_p3;
    t_s32 r2_a, r2_m, r3_a, r3_c, r4_v, r5_v, r5_dd, r6_v, r6_q;
    logic [13:0] r7_h;
    logic r1_ok, r2_ok, r3_ok, r4_ok, r5_ok, r6_ok, r7_ok;

    assign w_vh = i_tf - 32'sd76800;
    assign w_h5 = i_h5;
    assign w_h6 = i_h6;
    assign w_h2 = i_h2;
    assign w_h3 = t_s32'({24'b0, i_h3});
    assign w_h1 = t_s32'({24'b0, i_h1});

    // final subtract and clamp to 0..419430400
    assign w_r = r6_v - (r6_q >>> 4);
    always_comb begin
        if (w_r < 32'sd0) begin
            w_c = '0;
        end else if (w_r > 32'sd419430400) begin
            w_c = 32'sd419430400;
        end else begin
            w_c = w_r;
        end
    end
    assign w_hm = {7'b0, w_c[28:12]} * 24'd100;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_base <= t_s32'({2'b0, i_raw_h, 14'b0}) - t_s32'({i_h4, 20'b0});
            r1_p5   <= w_h5 * w_vh;
            r1_p6   <= w_vh * w_h6;
            r1_p3   <= w_vh * w_h3;
            r1_ok   <= (i_raw_h != RAW_SKIP16);
            r2_a    <= (r1_base - r1_p5 + 32'sd16384) >>> 15;
            r2_m    <= (r1_p6 >>> 10) * ((r1_p3 >>> 11) + 32'sd32768);
            r2_ok   <= r1_ok;
            r3_a    <= r2_a;
            r3_c    <= ((r2_m >>> 10) + 32'sd2097152) * w_h2;
            r3_ok   <= r2_ok;
            r4_v    <= r3_a * ((r3_c + 32'sd8192) >>> 14);
            r4_ok   <= r3_ok;
            r5_v    <= r4_v;
            r5_dd   <= (r4_v >>> 15) * (r4_v >>> 15);
            r5_ok   <= r4_ok;
            r6_v    <= r5_v;
            r6_q    <= (r5_dd >>> 7) * w_h1;
            r6_ok   <= r5_ok;
            r7_h    <= r6_ok ? w_hm[23:10] : '0;
            r7_ok   <= r6_ok;
        end
    end

    assign o_hum   = r7_h;
    assign o_hum_v = r7_ok;

endmodule

`default_nettype wire

@@ design/esc_div.sv @@
// ----------------------------------------------------------------------------
// esc_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_div #(
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic      [W-1:0] o_quo
);
    logic [W-1:0] r_rem [0:W-1];
    logic [W-1:0] r_num [0:W-1];
    logic [W-1:0] r_den [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] w_rem_in, w_num_in, w_den_in;
        logic [W:0]   w_trial, w_diff;
        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_num_in = r_num[k-1];
            assign w_den_in = r_den[k-1];
        end
        assign w_trial = {w_rem_in, w_num_in[W-1]};
        assign w_diff  = w_trial - {1'b0, w_den_in};

        // shift in one dividend bit, subtract when it fits
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_diff[W] ? w_trial[W-1:0] : w_diff[W-1:0];
                r_num[k] <= {w_num_in[W-2:0], ~w_diff[W]};
                r_den[k] <= w_den_in;
            end
        end
    end

    assign o_quo = r_num[W-1];

endmodule

`default_nettype wire

@@ design/esc_pres.sv @@
// ----------------------------------------------------------------------------
// esc_pres
// Pressure compensation: five setup stages, pipelined divide, four finish stages.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_pres (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  esc_pkg::t_s32           i_tf,
    input  wire logic [23:0]        i_raw_p,
    input  wire logic [15:0]        i_p1,
    input  wire logic signed [15:0] i_p2,
    input  wire logic signed [15:0] i_p3,
    input  wire logic signed [15:0] i_p4,
    input  wire logic signed [15:0] i_p5,
    input  wire logic signed [15:0] i_p6,
    input  wire logic signed [15:0] i_p7,
    input  wire logic signed [15:0] i_p8,
    input  wire logic signed [15:0] i_p9,
    output logic [15:0]             o_pres,
    output logic                    o_pres_v,
    output logic                    o_status
);
    import esc_pkg::*;

    t_s32 w_v1, w_q, w_p2, w_p3, w_p5, w_p6, w_p8, w_p9, w_p7, w_n0, w_div, w_adj;
    t_s32 r1_qq, r1_m5, r1_m2, r2_t11, r2_t13, r2_m5, r2_m2, r3_v2, r3_s, r4_m;
    t_s32 r6_m8, r7_m9, r7_m8;
    logic [19:0] r1_x, r2_x, r3_x;
    logic [31:0] r4_n, r5_num, r5_den, w_quo, w_p, r6_p, r7_p, r8_pf, r6_ss;
    logic [31:0] w_sq;
    logic [64:0] w_prod;
    logic r1_ok, r2_ok, r3_ok, r4_ok, r5_ok, r5_big, r5_zero;
    logic w_big, w_zero, w_ok, r6_ok, r6_zero, r7_ok, r7_zero, r8_ok, r8_zero;
    logic [15:0] r9_pres;
    logic r9_ok, r9_stat;

    assign w_v1 = (i_tf >>> 1) - 32'sd64000;
    assign w_q  = w_v1 >>> 2;
    assign w_p2 = i_p2;
    assign w_p3 = i_p3;
    assign w_p5 = i_p5;
    assign w_p6 = i_p6;
    assign w_p7 = i_p7;
    assign w_p8 = i_p8;
    assign w_p9 = i_p9;
    assign w_n0 = t_s32'(32'd1048576 - {12'b0, r3_x}) - (r3_v2 >>> 12);
    assign w_div = r4_m >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qq   <= w_q * w_q;
            r1_m5   <= w_v1 * w_p5;
            r1_m2   <= w_p2 * w_v1;
            r1_x    <= i_raw_p[23:4];
            r1_ok   <= (i_raw_p != RAW_SKIP24);
            r2_t11  <= (r1_qq >>> 11) * w_p6;
            r2_t13  <= w_p3 * (r1_qq >>> 13);
            r2_m5   <= r1_m5;
            r2_m2   <= r1_m2;
            r2_x    <= r1_x;
            r2_ok   <= r1_ok;
            r3_v2   <= ((r2_t11 + (r2_m5 <<< 1)) >>> 2) + t_s32'({i_p4, 16'b0});
            r3_s    <= 32'sd32768 + (((r2_t13 >>> 3) + (r2_m2 >>> 1)) >>> 18);
            r3_x    <= r2_x;
            r3_ok   <= r2_ok;
            r4_m    <= r3_s * t_s32'({16'b0, i_p1});
            r4_n    <= 32'(w_n0 * 32'sd3125);
            r4_ok   <= r3_ok;
            // double the dividend when it fits, else double the quotient later
            r5_big  <= r4_n[31];
            r5_num  <= r4_n[31] ? r4_n : {r4_n[30:0], 1'b0};
            r5_den  <= 32'(w_div);
            r5_zero <= (w_div == 32'sd0);
            r5_ok   <= r4_ok;
        end
    end

    esc_div #(.W(DIV_W)) u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r5_num),
        .i_den (r5_den),
        .o_quo (w_quo)
    );

    esc_dly #(.W(3), .N(DIV_W)) u_flags (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r5_big, r5_zero, r5_ok}),
        .o_q   ({w_big, w_zero, w_ok})
    );

    assign w_p    = w_big ? {w_quo[30:0], 1'b0} : w_quo;
    // square wraps at 32 bits before the shift
    assign w_sq   = {3'b0, w_p[31:3]} * {3'b0, w_p[31:3]};
    assign w_adj  = ((r7_m9 >>> 12) + (r7_m8 >>> 13) + w_p7) >>> 4;
    assign w_prod = {33'b0, r8_pf} * 65'h0CCCCCCCD;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_p    <= w_p;
            r6_ss   <= {13'b0, w_sq[31:13]};
            r6_m8   <= t_s32'({2'b0, w_p[31:2]}) * w_p8;
            r6_ok   <= w_ok;
            r6_zero <= w_zero;
            r7_p    <= r6_p;
            r7_m9   <= w_p9 * t_s32'(r6_ss);
            r7_m8   <= r6_m8;
            r7_ok   <= r6_ok;
            r7_zero <= r6_zero;
            r8_pf   <= r7_p + 32'(w_adj);
            r8_ok   <= r7_ok;
            r8_zero <= r7_zero;
            // divide by ten through the reciprocal
            r9_pres <= (r8_ok && !r8_zero) ? w_prod[50:35] : '0;
            r9_ok   <= r8_ok;
            r9_stat <= r8_ok && r8_zero;
        end
    end

    assign o_pres   = r9_pres;
    assign o_pres_v = r9_ok;
    assign o_status = r9_stat;

endmodule

`default_nettype wire
